// ===== sv/assert_macros.svh =====
// Assertion macros for the checker file of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with asynchronous active-low reset disable.
`define PPMP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: assertion failed");

// Same-cycle implication.
`define PPMP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  `PPMP_ASSERT(lbl, clk, rst_n, (ante) |-> (cons))

// Next-cycle implication.
`define PPMP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  `PPMP_ASSERT(lbl, clk, rst_n, (ante) |=> (cons))

`endif

// ===== sv/ppmp_pkg.sv =====
// Types, constants and codes of the PPM byte stream parser.
package ppmp_pkg;

  localparam int DimBits    = 16;
  localparam int TokBits    = (DimBits < 9) ? 9 : DimBits;
  localparam int MulBits    = TokBits + 4;
  localparam int CntBits    = 32;
  localparam int AreaBits   = 2 * DimBits;
  localparam int CmpBits    = (AreaBits > CntBits) ? AreaBits : CntBits;
  localparam int OutDimBits = 16;

  localparam logic [DimBits-1:0] DimMax   = '1;
  localparam logic [TokBits-1:0] TokenMax = TokBits'(DimMax) | TokBits'(511);
  localparam logic [CntBits-1:0] CntMax   = '1;
  localparam logic [7:0]         MaxVal   = 8'd255;

  localparam logic [7:0] CharP     = 8'h50;
  localparam logic [7:0] Char3     = 8'h33;
  localparam logic [7:0] Char6     = 8'h36;
  localparam logic [7:0] CharHash  = 8'h23;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharNl    = 8'h0A;
  localparam logic [7:0] Char0     = 8'h30;
  localparam logic [7:0] Char9     = 8'h39;

  typedef enum logic [2:0] {
    PH_MAGIC,
    PH_FORMAT,
    PH_HEADER,
    PH_DATA,
    PH_DONE,
    PH_HALT
  } phase_e;

  typedef enum logic [1:0] {
    EV_NONE,
    EV_HEADER,
    EV_PIXEL,
    EV_ERROR
  } event_e;

  typedef enum logic [2:0] {
    ERR_NONE,
    ERR_NOT_P,
    ERR_FORMAT,
    ERR_MAXVAL,
    ERR_BYTE
  } err_e;

  typedef struct packed {
    event_e                ev;
    err_e                  err;
    logic [7:0]            red;
    logic [7:0]            green;
    logic [7:0]            blue;
    logic [OutDimBits-1:0] width;
    logic [OutDimBits-1:0] height;
    logic                  fin;
  } res_t;

endpackage

// ===== sv/ppm_byte_stream_parser_top.sv =====
// PPM (P3/P6) byte stream parser, top level.
// Takes one byte of a portable pixmap file per transaction and returns one
// result per byte, in the cycle after the byte is accepted: header complete,
// pixel ready, error, or nothing. A byte can be accepted every cycle; the
// parser state is updated in the accepting cycle and the result lands in a
// single output register, so s_axis_tready drops only while that register
// holds a result that the downstream side is not taking. The width by height
// product used to find the last P6 pixel is computed in its own registered
// multiplier from the stored header values.
module ppm_byte_stream_parser_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] first_byte
  input  logic        s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [7:0] red, [15:8] green, [23:16] blue,
                                      // [39:24] image_width, [55:40] image_height,
                                      // [58:56] error_code, [63:59] zero
  output logic [1:0]  m_axis_tuser,   // [1:0] event_res
  output logic        m_axis_tlast    // final_pixel
);

  logic                          accept;
  logic [ppmp_pkg::DimBits-1:0]  width;
  logic [ppmp_pkg::DimBits-1:0]  height;
  logic [ppmp_pkg::AreaBits-1:0] area;
  ppmp_pkg::res_t                res_new;
  ppmp_pkg::res_t                res_out;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  ppmp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (s_axis_tdata),
    .first_i     (s_axis_tuser),
    .last_i      (s_axis_tlast),
    .area_i      (area),
    .width_o     (width),
    .height_o    (height),
    .res_o       (res_new)
  );

  ppmp_area u_area (
    .clk_i    (clk_i),
    .width_i  (width),
    .height_i (height),
    .area_o   (area)
  );

  ppmp_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (accept),
    .res_i   (res_new),
    .ready_i (m_axis_tready),
    .valid_o (m_axis_tvalid),
    .res_o   (res_out)
  );

  assign m_axis_tdata = {5'b0, res_out.err, res_out.height, res_out.width,
                         res_out.blue, res_out.green, res_out.red};
  assign m_axis_tuser = res_out.ev;
  assign m_axis_tlast = res_out.fin;

endmodule

// ===== sv/ppmp_area.sv =====
// Registered width by height product for the end-of-image compare.
module ppmp_area (
  input  logic                          clk_i,
  input  logic [ppmp_pkg::DimBits-1:0]  width_i,
  input  logic [ppmp_pkg::DimBits-1:0]  height_i,
  output logic [ppmp_pkg::AreaBits-1:0] area_o
);

  logic [ppmp_pkg::AreaBits-1:0] area_q;
  logic [ppmp_pkg::AreaBits-1:0] area_d;

  assign area_d = ppmp_pkg::AreaBits'(width_i) * ppmp_pkg::AreaBits'(height_i);

  // Height settles at least one item before the first data byte.
  always_ff @(posedge clk_i) begin
    area_q <= area_d;
  end

  assign area_o = area_q;

endmodule

// ===== sv/ppmp_core.sv =====
// Parser state registers and the per-byte next-state and result logic.
module ppmp_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic [7:0]                    data_byte_i,
  input  logic                          first_i,
  input  logic                          last_i,
  input  logic [ppmp_pkg::AreaBits-1:0] area_i,
  output logic [ppmp_pkg::DimBits-1:0]  width_o,
  output logic [ppmp_pkg::DimBits-1:0]  height_o,
  output ppmp_pkg::res_t                res_o
);

  ppmp_pkg::phase_e phase_q, phase_d, eff_phase;
  logic binary_q, binary_d, eff_binary;
  logic comment_q, comment_d, eff_comment;
  logic [ppmp_pkg::TokBits-1:0] tok_q, tok_d, eff_tok;
  logic open_q, open_d, eff_open;
  logic [1:0] field_q, field_d, eff_field;
  logic [1:0] ch_q, ch_d, eff_ch;
  logic [7:0] red_q, red_d, eff_red;
  logic [7:0] green_q, green_d, eff_green;
  logic [ppmp_pkg::DimBits-1:0] width_q, width_d, eff_width;
  logic [ppmp_pkg::DimBits-1:0] height_q, height_d, eff_height;
  logic [ppmp_pkg::CntBits-1:0] cnt_q, cnt_d, eff_cnt;

  logic                         is_digit, is_sep, is_hash;
  logic [3:0]                   digit;
  logic [ppmp_pkg::MulBits-1:0] tok_mul;
  logic [ppmp_pkg::TokBits-1:0] hdr_tok_new, hdr_val;
  logic [ppmp_pkg::TokBits-1:0] dat_tok_new;
  logic [ppmp_pkg::DimBits-1:0] hdr_dim;
  logic [7:0]                   dat_val;
  logic                         hdr_close, dat_close, maxval_ok, p6_hit;
  logic [ppmp_pkg::CntBits-1:0] cnt_inc;

  // A first byte restarts from the reset state before this byte is parsed.
  assign eff_phase   = first_i ? ppmp_pkg::PH_MAGIC : phase_q;
  assign eff_binary  = first_i ? 1'b0 : binary_q;
  assign eff_comment = first_i ? 1'b0 : comment_q;
  assign eff_tok     = first_i ? '0 : tok_q;
  assign eff_open    = first_i ? 1'b0 : open_q;
  assign eff_field   = first_i ? 2'd0 : field_q;
  assign eff_ch      = first_i ? 2'd0 : ch_q;
  assign eff_red     = first_i ? 8'd0 : red_q;
  assign eff_green   = first_i ? 8'd0 : green_q;
  assign eff_width   = first_i ? '0 : width_q;
  assign eff_height  = first_i ? '0 : height_q;
  assign eff_cnt     = first_i ? '0 : cnt_q;

  assign is_digit = (data_byte_i >= ppmp_pkg::Char0) && (data_byte_i <= ppmp_pkg::Char9);
  assign is_sep   = (data_byte_i == ppmp_pkg::CharSpace) || (data_byte_i == ppmp_pkg::CharNl);
  assign is_hash  = (data_byte_i == ppmp_pkg::CharHash);
  assign digit    = 4'(data_byte_i - ppmp_pkg::Char0);

  // Times ten as two shifts and an add.
  assign tok_mul = (ppmp_pkg::MulBits'(eff_tok) << 3) + (ppmp_pkg::MulBits'(eff_tok) << 1)
                 + ppmp_pkg::MulBits'(digit);

  assign hdr_tok_new = (tok_mul > ppmp_pkg::MulBits'(ppmp_pkg::TokenMax)) ?
                       ppmp_pkg::TokenMax : tok_mul[ppmp_pkg::TokBits-1:0];
  assign dat_tok_new = (tok_mul > ppmp_pkg::MulBits'(ppmp_pkg::MaxVal)) ?
                       ppmp_pkg::TokBits'(ppmp_pkg::MaxVal) : tok_mul[ppmp_pkg::TokBits-1:0];

  // A digit on the last byte closes the token it just extended.
  assign hdr_close = (eff_phase == ppmp_pkg::PH_HEADER) && !eff_comment &&
                     ((is_digit && last_i) || ((is_sep || is_hash) && eff_open));
  assign hdr_val   = is_digit ? hdr_tok_new : eff_tok;
  assign hdr_dim   = (hdr_val > ppmp_pkg::TokBits'(ppmp_pkg::DimMax)) ?
                     ppmp_pkg::DimMax : ppmp_pkg::DimBits'(hdr_val);
  assign maxval_ok = (hdr_val == ppmp_pkg::TokBits'(ppmp_pkg::MaxVal));

  assign dat_close = (eff_phase == ppmp_pkg::PH_DATA) && !eff_binary &&
                     ((is_digit && last_i) || (is_sep && eff_open));
  assign dat_val   = is_digit ? 8'(dat_tok_new) : 8'(eff_tok);

  assign cnt_inc = (eff_cnt == ppmp_pkg::CntMax) ? eff_cnt : eff_cnt + 1'b1;
  assign p6_hit  = (ppmp_pkg::CmpBits'(cnt_inc) == ppmp_pkg::CmpBits'(area_i));

  // Next state.
  always_comb begin
    phase_d  = eff_phase;
    binary_d = eff_binary;
    comment_d = eff_comment;
    tok_d    = eff_tok;
    open_d   = eff_open;
    field_d  = eff_field;
    ch_d     = eff_ch;
    red_d    = eff_red;
    green_d  = eff_green;
    width_d  = eff_width;
    height_d = eff_height;
    cnt_d    = eff_cnt;
    case (eff_phase)
      ppmp_pkg::PH_MAGIC: begin
        phase_d = (data_byte_i == ppmp_pkg::CharP) ? ppmp_pkg::PH_FORMAT : ppmp_pkg::PH_HALT;
      end
      ppmp_pkg::PH_FORMAT: begin
        if (data_byte_i == ppmp_pkg::Char3) begin
          binary_d = 1'b0;
          phase_d  = ppmp_pkg::PH_HEADER;
        end else if (data_byte_i == ppmp_pkg::Char6) begin
          binary_d = 1'b1;
          phase_d  = ppmp_pkg::PH_HEADER;
        end else begin
          phase_d = ppmp_pkg::PH_HALT;
        end
      end
      ppmp_pkg::PH_HEADER: begin
        if (eff_comment) begin
          if (data_byte_i == ppmp_pkg::CharNl) comment_d = 1'b0;
        end else if (is_digit) begin
          tok_d  = hdr_tok_new;
          open_d = 1'b1;
        end else if (is_hash) begin
          // Closing the max value leaves the header, so no comment starts.
          comment_d = !(eff_open && (eff_field == 2'd2));
        end else if (!is_sep) begin
          phase_d = ppmp_pkg::PH_HALT;
        end
        if (hdr_close) begin
          tok_d  = '0;
          open_d = 1'b0;
          case (eff_field)
            2'd0: begin
              width_d = hdr_dim;
              field_d = 2'd1;
            end
            2'd1: begin
              height_d = hdr_dim;
              field_d  = 2'd2;
            end
            default: begin
              if (!maxval_ok) begin
                phase_d = ppmp_pkg::PH_HALT;
              end else begin
                ch_d      = 2'd0;
                cnt_d     = '0;
                comment_d = 1'b0;
                if (eff_binary && ((eff_width == '0) || (eff_height == '0)))
                  phase_d = ppmp_pkg::PH_DONE;
                else
                  phase_d = ppmp_pkg::PH_DATA;
              end
            end
          endcase
        end
      end
      ppmp_pkg::PH_DATA: begin
        if (!eff_binary) begin
          if (is_digit) begin
            tok_d  = dat_tok_new;
            open_d = 1'b1;
          end else if (!is_sep) begin
            phase_d = ppmp_pkg::PH_HALT;
          end
          if (dat_close) begin
            tok_d  = '0;
            open_d = 1'b0;
            case (eff_ch)
              2'd0: begin
                red_d = dat_val;
                ch_d  = 2'd1;
              end
              2'd1: begin
                green_d = dat_val;
                ch_d    = 2'd2;
              end
              default: begin
                ch_d  = 2'd0;
                cnt_d = cnt_inc;
              end
            endcase
          end
        end else begin
          case (eff_ch)
            2'd0: begin
              red_d = data_byte_i;
              ch_d  = 2'd1;
            end
            2'd1: begin
              green_d = data_byte_i;
              ch_d    = 2'd2;
            end
            default: begin
              ch_d  = 2'd0;
              cnt_d = cnt_inc;
              if (p6_hit) phase_d = ppmp_pkg::PH_DONE;
            end
          endcase
        end
      end
      default: ;
    endcase
  end

  // Result of this byte.
  always_comb begin
    res_o        = '0;
    res_o.ev     = ppmp_pkg::EV_NONE;
    res_o.err    = ppmp_pkg::ERR_NONE;
    res_o.width  = ppmp_pkg::OutDimBits'(width_d);
    res_o.height = ppmp_pkg::OutDimBits'(height_d);
    case (eff_phase)
      ppmp_pkg::PH_MAGIC: begin
        if (data_byte_i != ppmp_pkg::CharP) begin
          res_o.ev  = ppmp_pkg::EV_ERROR;
          res_o.err = ppmp_pkg::ERR_NOT_P;
        end
      end
      ppmp_pkg::PH_FORMAT: begin
        if ((data_byte_i != ppmp_pkg::Char3) && (data_byte_i != ppmp_pkg::Char6)) begin
          res_o.ev  = ppmp_pkg::EV_ERROR;
          res_o.err = ppmp_pkg::ERR_FORMAT;
        end
      end
      ppmp_pkg::PH_HEADER: begin
        if (!eff_comment && !is_digit && !is_sep && !is_hash) begin
          res_o.ev  = ppmp_pkg::EV_ERROR;
          res_o.err = ppmp_pkg::ERR_BYTE;
        end else if (hdr_close && (eff_field == 2'd2)) begin
          if (maxval_ok) begin
            res_o.ev = ppmp_pkg::EV_HEADER;
          end else begin
            res_o.ev  = ppmp_pkg::EV_ERROR;
            res_o.err = ppmp_pkg::ERR_MAXVAL;
          end
        end
      end
      ppmp_pkg::PH_DATA: begin
        if (!eff_binary) begin
          if (!is_digit && !is_sep) begin
            res_o.ev  = ppmp_pkg::EV_ERROR;
            res_o.err = ppmp_pkg::ERR_BYTE;
          end else if (dat_close && (eff_ch == 2'd2)) begin
            res_o.ev    = ppmp_pkg::EV_PIXEL;
            res_o.red   = eff_red;
            res_o.green = eff_green;
            res_o.blue  = dat_val;
          end
        end else if (eff_ch == 2'd2) begin
          res_o.ev    = ppmp_pkg::EV_PIXEL;
          res_o.red   = eff_red;
          res_o.green = eff_green;
          res_o.blue  = data_byte_i;
          res_o.fin   = p6_hit;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= ppmp_pkg::PH_MAGIC;
      binary_q  <= 1'b0;
      comment_q <= 1'b0;
      tok_q     <= '0;
      open_q    <= 1'b0;
      field_q   <= 2'd0;
      ch_q      <= 2'd0;
      red_q     <= 8'd0;
      green_q   <= 8'd0;
      width_q   <= '0;
      height_q  <= '0;
      cnt_q     <= '0;
    end else if (accept_i) begin
      phase_q   <= phase_d;
      binary_q  <= binary_d;
      comment_q <= comment_d;
      tok_q     <= tok_d;
      open_q    <= open_d;
      field_q   <= field_d;
      ch_q      <= ch_d;
      red_q     <= red_d;
      green_q   <= green_d;
      width_q   <= width_d;
      height_q  <= height_d;
      cnt_q     <= cnt_d;
    end
  end

  assign width_o  = width_q;
  assign height_o = height_q;

endmodule

// ===== sv/ppmp_out_reg.sv =====
// Result register: holds one transaction until the downstream side takes it.
module ppmp_out_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  ppmp_pkg::res_t res_i,
  input  logic           ready_i,
  output logic           valid_o,
  output ppmp_pkg::res_t res_o
);

  logic           valid_q, valid_d;
  ppmp_pkg::res_t res_q;

  assign valid_d = load_i ? 1'b1 : (ready_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) res_q <= res_i;
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// ===== sv/ppmp_checker.sv =====
// Port-level checker for the PPM byte stream parser, bound to the top level.
`include "assert_macros.svh"

module ppmp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  // A stalled result holds.
  `PPMP_ASSERT_NXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

  // Input backpressure only comes from a stalled output.
  `PPMP_ASSERT_IMP(a_ready, clk_i, rst_ni, !s_axis_tready, m_axis_tvalid && !m_axis_tready)

  // Channels are zero unless a pixel is reported.
  `PPMP_ASSERT_IMP(a_rgb, clk_i, rst_ni, m_axis_tvalid && (m_axis_tuser != ppmp_pkg::EV_PIXEL), m_axis_tdata[23:0] == 24'd0)

  // Error code is set exactly on error events.
  `PPMP_ASSERT_IMP(a_err, clk_i, rst_ni, m_axis_tvalid, (m_axis_tuser == ppmp_pkg::EV_ERROR) == (m_axis_tdata[58:56] != 3'd0))

  // Final pixel flag only rides on a pixel event.
  `PPMP_ASSERT_IMP(a_fin, clk_i, rst_ni, m_axis_tvalid && m_axis_tlast, m_axis_tuser == ppmp_pkg::EV_PIXEL)

endmodule

bind ppm_byte_stream_parser_top ppmp_checker u_ppmp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the PPM byte stream parser: stimulus, scoreboard and checks.
module tb;

  class ppm_parse_scoreboard;
    ppmp_pkg::phase_e phase;
    bit               binary;
    bit               in_comment;
    logic [63:0]      token;
    bit               token_open;
    int unsigned      hdr_idx;
    int unsigned      chan;
    logic [7:0]       held_r;
    logic [7:0]       held_g;
    logic [63:0]      width_q;
    logic [63:0]      height_q;
    logic [31:0]      pix_cnt;
    ppmp_pkg::res_t   outcome;
    ppmp_pkg::res_t   due_results[$];
    int unsigned      checked;
    int unsigned      mismatches;
    int unsigned      headers_seen;
    int unsigned      pixels_seen;
    int unsigned      finals_seen;
    int unsigned      errors_seen;

    function new();
      restart();
    endfunction

    function void restart();
      phase      = ppmp_pkg::PH_MAGIC;
      binary     = 1'b0;
      in_comment = 1'b0;
      token      = '0;
      token_open = 1'b0;
      hdr_idx    = 0;
      chan       = 0;
      held_r     = '0;
      held_g     = '0;
      width_q    = '0;
      height_q   = '0;
      pix_cnt    = '0;
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= 100) $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    function void halt_on(ppmp_pkg::err_e code);
      outcome.ev  = ppmp_pkg::EV_ERROR;
      outcome.err = code;
      phase       = ppmp_pkg::PH_HALT;
    endfunction

    function bit is_digit(logic [7:0] b);
      return b >= ppmp_pkg::Char0 && b <= ppmp_pkg::Char9;
    endfunction

    function bit is_sep(logic [7:0] b);
      return b == ppmp_pkg::CharSpace || b == ppmp_pkg::CharNl;
    endfunction

    function void close_header();
      logic [63:0] v;
      v          = token;
      token      = '0;
      token_open = 1'b0;
      if (hdr_idx == 0) begin
        width_q = (v > 64'(ppmp_pkg::DimMax)) ? 64'(ppmp_pkg::DimMax) : v;
        hdr_idx = 1;
      end else if (hdr_idx == 1) begin
        height_q = (v > 64'(ppmp_pkg::DimMax)) ? 64'(ppmp_pkg::DimMax) : v;
        hdr_idx  = 2;
      end else if (v != 64'(ppmp_pkg::MaxVal)) begin
        halt_on(ppmp_pkg::ERR_MAXVAL);
      end else begin
        outcome.ev = ppmp_pkg::EV_HEADER;
        phase      = ppmp_pkg::PH_DATA;
        chan       = 0;
        pix_cnt    = '0;
        in_comment = 1'b0;
        if (binary && width_q * height_q == 0) phase = ppmp_pkg::PH_DONE;
      end
    endfunction

    function void take_channel(logic [7:0] v);
      if (chan == 0) begin
        held_r = v;
        chan   = 1;
      end else if (chan == 1) begin
        held_g = v;
        chan   = 2;
      end else begin
        outcome.ev    = ppmp_pkg::EV_PIXEL;
        outcome.red   = held_r;
        outcome.green = held_g;
        outcome.blue  = v;
        chan          = 0;
        if (pix_cnt != ppmp_pkg::CntMax) pix_cnt++;
      end
    endfunction

    function void close_data();
      logic [7:0] v;
      v          = token[7:0];
      token      = '0;
      token_open = 1'b0;
      take_channel(v);
    endfunction

    // Work out the result of one accepted byte and queue it.
    function void parse_byte(logic [7:0] b, logic first, logic last);
      outcome = '0;
      if (first) restart();
      case (phase)
        ppmp_pkg::PH_MAGIC: begin
          if (b == ppmp_pkg::CharP) phase = ppmp_pkg::PH_FORMAT;
          else halt_on(ppmp_pkg::ERR_NOT_P);
        end
        ppmp_pkg::PH_FORMAT: begin
          if (b == ppmp_pkg::Char3 || b == ppmp_pkg::Char6) begin
            binary = (b == ppmp_pkg::Char6);
            phase  = ppmp_pkg::PH_HEADER;
          end else begin
            halt_on(ppmp_pkg::ERR_FORMAT);
          end
        end
        ppmp_pkg::PH_HEADER: begin
          if (in_comment) begin
            if (b == ppmp_pkg::CharNl) in_comment = 1'b0;
          end else if (is_digit(b)) begin
            token = token * 10 + 64'(b - ppmp_pkg::Char0);
            if (token > 64'(ppmp_pkg::TokenMax)) token = 64'(ppmp_pkg::TokenMax);
            token_open = 1'b1;
          end else if (is_sep(b)) begin
            if (token_open) close_header();
          end else if (b == ppmp_pkg::CharHash) begin
            if (token_open) close_header();
            if (phase == ppmp_pkg::PH_HEADER) in_comment = 1'b1;
          end else begin
            halt_on(ppmp_pkg::ERR_BYTE);
          end
          if (last && phase == ppmp_pkg::PH_HEADER && token_open) close_header();
        end
        ppmp_pkg::PH_DATA: begin
          if (!binary) begin
            if (is_digit(b)) begin
              token = token * 10 + 64'(b - ppmp_pkg::Char0);
              if (token > 64'(ppmp_pkg::MaxVal)) token = 64'(ppmp_pkg::MaxVal);
              token_open = 1'b1;
            end else if (is_sep(b)) begin
              if (token_open) close_data();
            end else begin
              halt_on(ppmp_pkg::ERR_BYTE);
            end
            if (last && phase == ppmp_pkg::PH_DATA && token_open) close_data();
          end else begin
            take_channel(b);
            if (outcome.ev == ppmp_pkg::EV_PIXEL &&
                {32'd0, pix_cnt} == width_q * height_q) begin
              outcome.fin = 1'b1;
              phase       = ppmp_pkg::PH_DONE;
            end
          end
        end
        default: ;
      endcase
      outcome.width  = ppmp_pkg::OutDimBits'(width_q);
      outcome.height = ppmp_pkg::OutDimBits'(height_q);
      due_results.push_back(outcome);
    endfunction

    task compare_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want)
        report($sformatf("result %0d: %s got %0h, want %0h", checked, name, got, want));
    endtask

    task check_result(ppmp_pkg::res_t got);
      ppmp_pkg::res_t want;
      if (due_results.size() == 0) begin
        report($sformatf("result with nothing pending, event %0d", got.ev));
        return;
      end
      want = due_results.pop_front();
      compare_field("event", 16'(got.ev), 16'(want.ev));
      compare_field("error_code", 16'(got.err), 16'(want.err));
      compare_field("red", 16'(got.red), 16'(want.red));
      compare_field("green", 16'(got.green), 16'(want.green));
      compare_field("blue", 16'(got.blue), 16'(want.blue));
      compare_field("image_width", got.width, want.width);
      compare_field("image_height", got.height, want.height);
      compare_field("final_pixel", 16'(got.fin), 16'(want.fin));
      case (want.ev)
        ppmp_pkg::EV_HEADER: headers_seen++;
        ppmp_pkg::EV_PIXEL:  pixels_seen++;
        ppmp_pkg::EV_ERROR:  errors_seen++;
        default: ;
      endcase
      if (want.fin) finals_seen++;
      checked++;
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tuser;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  ppm_parse_scoreboard board;
  logic [7:0]          body[$];
  ppmp_pkg::res_t      seen;
  bit                  tx_calm;
  bit                  rx_calm;
  int unsigned         rx_stall;
  int unsigned         bytes_sent;
  int unsigned         files_sent;

  ppm_byte_stream_parser_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #4 clk_i = ~clk_i;

  // Check every accepted result and draw the stall before the next one.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen.ev     = ppmp_pkg::event_e'(m_axis_tuser);
      seen.err    = ppmp_pkg::err_e'(m_axis_tdata[58:56]);
      seen.red    = m_axis_tdata[7:0];
      seen.green  = m_axis_tdata[15:8];
      seen.blue   = m_axis_tdata[23:16];
      seen.width  = m_axis_tdata[39:24];
      seen.height = m_axis_tdata[55:40];
      seen.fin    = m_axis_tlast;
      board.check_result(seen);
      rx_stall = rx_calm ? 0 : $urandom_range(0, 6);
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready <= (rx_stall == 0);
    if (rx_stall != 0) rx_stall--;
  end

  task automatic push_byte(logic [7:0] b, logic f, logic l);
    int unsigned gap;
    gap = tx_calm ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= f;
    s_axis_tlast  <= l;
    do @(posedge clk_i); while (!s_axis_tready);
    board.parse_byte(b, f, l);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  // Send the bytes in body; mark the first byte as a restart when fresh.
  task automatic send_file(bit fresh, bit mess);
    int  i;
    bit  f;
    bit  l;
    for (i = 0; i < body.size(); i++) begin
      f = (i == 0 && fresh) || (mess && $urandom_range(0, 149) == 0);
      l = (i == body.size() - 1) || (mess && $urandom_range(0, 79) == 0);
      push_byte(body[i], f, l);
    end
    files_sent++;
  endtask

  task automatic push_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) body.push_back(s[i]);
  endtask

  task automatic add_num(longint unsigned v);
    if ($urandom_range(0, 9) == 0) body.push_back(ppmp_pkg::Char0);
    push_text($sformatf("%0d", v));
  endtask

  // Separator run; in the header it may be a comment instead.
  task automatic add_sep(bit hdr);
    int unsigned n;
    logic [7:0]  c;
    if (hdr && $urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(0, 1)) body.push_back(ppmp_pkg::CharSpace);
      body.push_back(ppmp_pkg::CharHash);
      repeat ($urandom_range(0, 5)) begin
        c = 8'($urandom_range(0, 255));
        body.push_back(c == ppmp_pkg::CharNl ? ppmp_pkg::CharSpace : c);
      end
      body.push_back(ppmp_pkg::CharNl);
    end else begin
      n = $urandom_range(1, 3);
      repeat (n) body.push_back($urandom_range(0, 1) ? ppmp_pkg::CharSpace : ppmp_pkg::CharNl);
    end
  endtask

  // Mostly well-formed P3/P6 files with random content and a few defects.
  task automatic build_file();
    bit          p6;
    bit          huge;
    int unsigned w;
    int unsigned h;
    int unsigned n;
    int unsigned pick;
    int          i;
    body.delete();
    p6   = $urandom_range(0, 1);
    pick = $urandom_range(0, 99);
    body.push_back(pick < 3 ? 8'($urandom) : ppmp_pkg::CharP);
    body.push_back((pick >= 3 && pick < 6) ? 8'($urandom) :
                   (p6 ? ppmp_pkg::Char6 : ppmp_pkg::Char3));
    if ($urandom_range(0, 1)) add_sep(1);
    w    = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
    h    = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
    huge = ($urandom_range(0, 14) == 0);
    add_num(huge ? 64'($urandom) + 64'd65536 : 64'(w));
    add_sep(1);
    add_num(h);
    add_sep(1);
    add_num(($urandom_range(0, 11) == 0) ? $urandom_range(0, 999) : 255);
    if ($urandom_range(0, 24) == 0) body.push_back(8'($urandom));
    n = huge ? 6 : w * h * 3;
    if (p6) begin
      if (n != 0 || $urandom_range(0, 1))
        body.push_back(($urandom_range(0, 9) == 0) ? ppmp_pkg::CharHash :
                       ($urandom_range(0, 1) ? ppmp_pkg::CharSpace : ppmp_pkg::CharNl));
      if (n > 2 && $urandom_range(0, 5) == 0) n = n - $urandom_range(1, 2);
      else if ($urandom_range(0, 5) == 0) n = n + $urandom_range(1, 4);
      repeat (n) body.push_back(8'($urandom));
    end else begin
      add_sep(0);
      if (n > 2 && $urandom_range(0, 5) == 0) n = n - $urandom_range(1, 2);
      for (i = 0; i < n; i++) begin
        add_num(($urandom_range(0, 9) == 0) ? $urandom_range(256, 999) :
                $urandom_range(0, 255));
        if ($urandom_range(0, 39) == 0)
          body.push_back($urandom_range(0, 1) ? ppmp_pkg::CharHash :
                         8'($urandom_range(8'h41, 8'h7A)));
        if (i != n - 1 || $urandom_range(0, 1)) add_sep(0);
      end
    end
  endtask

  initial begin
    #3000000;
    $display("Timeout with %0d results outstanding", board.due_results.size());
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    rx_stall      = 0;
    tx_calm       = 1'b0;
    rx_calm       = 1'b0;
    board         = new();
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Wrong magic letter, wrong format digit followed by a halted byte.
    body.delete();
    push_text("X");
    send_file(1, 0);
    body.delete();
    push_text("P7");
    body.push_back(8'hFF);
    send_file(1, 0);
    // One-pixel binary image with extreme bytes, then a byte past the end.
    body.delete();
    push_text("P6 1 1 255\n");
    body.push_back(8'h00);
    body.push_back(8'hFF);
    body.push_back(8'h80);
    body.push_back(8'h00);
    send_file(1, 0);
    // Empty binary image whose max value is closed by the final byte.
    body.delete();
    push_text("P60 5 255");
    send_file(1, 0);

    while (bytes_sent < 1950) begin
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 19) == 0) begin
        body.delete();
        repeat ($urandom_range(1, 8)) body.push_back(8'($urandom));
        send_file($urandom_range(0, 1), 1);
      end else begin
        build_file();
        send_file(1, 1);
      end
    end
    s_axis_tvalid <= 1'b0;

    while (board.due_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    $display("Sent %0d bytes in %0d files; checked %0d results: %0d headers, %0d pixels,",
             bytes_sent, files_sent, board.checked, board.headers_seen, board.pixels_seen);
    $display("  %0d last binary pixels, %0d error events, %0d mismatches.",
             board.finals_seen, board.errors_seen, board.mismatches);
    if (board.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+sv
sv/ppmp_pkg.sv
sv/ppmp_area.sv
sv/ppmp_core.sv
sv/ppmp_out_reg.sv
sv/ppm_byte_stream_parser_top.sv
sv/ppmp_checker.sv
tb/sv/tb.sv
